>>> rtl/core/fos_pkg.sv
// fos_pkg: shared types, constants and the rule table of the fuzzy obstacle steering unit
// depends on nothing; imported by every module of the block
`default_nettype none
package fos_pkg;

	localparam int DIST_W      = 16;
	localparam int MEMB_W      = 16;
	localparam int NUM_REGS    = 7;
	localparam int REG_IDX_W   = 3;
	localparam int PADDR_W     = 5;
	localparam int PDATA_W     = 32;

	localparam logic [MEMB_W-1:0] MEMB_ONE    = 16'h8000;
	localparam logic [MEMB_W-1:0] MEMB_THRESH = 16'd3;

	// divider shapes
	localparam int SLOPE_Q_W   = 15;
	localparam int AVG_Q_W     = 14;
	localparam int AVG_DEN_W   = 21;
	localparam int AVG_NUM_W   = 35;

	// prep stage, slope divider, four merge stages, averaging divider
	localparam int PIPE_LAT    = 1 + SLOPE_Q_W + 4 + AVG_Q_W;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_NEAR_FULL_UNTIL   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NEAR_ZERO_FROM    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_MEDIUM_RISE_START = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MEDIUM_PEAK_AT    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MEDIUM_FALL_END   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FAR_RISE_START    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_FAR_FULL_FROM     = 3'd6;

	// membership kind chosen ahead of the slope divider
	localparam logic [1:0] MODE_ZERO  = 2'd0;
	localparam logic [1:0] MODE_ONE   = 2'd1;
	localparam logic [1:0] MODE_SLOPE = 2'd2;

	typedef logic [MEMB_W-1:0] memb_t;
	typedef memb_t [2:0] memb_set_t;

	typedef struct packed {
		logic [DIST_W-1:0] near_full_until;
		logic [DIST_W-1:0] near_zero_from;
		logic [DIST_W-1:0] medium_rise_start;
		logic [DIST_W-1:0] medium_peak_at;
		logic [DIST_W-1:0] medium_fall_end;
		logic [DIST_W-1:0] far_rise_start;
		logic [DIST_W-1:0] far_full_from;
	} fos_cfg_t;

	typedef struct packed {
		logic [DIST_W-1:0] left_distance;
		logic [DIST_W-1:0] middle_distance;
		logic [DIST_W-1:0] right_distance;
	} fos_in_t;

	typedef struct packed {
		logic signed [14:0] steer_offset;
		logic               no_rule_fired;
	} fos_out_t;

	// steering level per rule, index left*9 + middle*3 + right, in units of 6144
	localparam logic signed [2:0] STEER_LEVEL [27] = '{
		-3'sd2, -3'sd2, -3'sd2,  -3'sd2, -3'sd1, -3'sd1,  -3'sd2, -3'sd1,  3'sd0,
		-3'sd2, -3'sd1, -3'sd1,  -3'sd1,  3'sd0,  3'sd1,  -3'sd1,  3'sd1,  3'sd2,
		-3'sd1,  3'sd0,  3'sd1,   3'sd1,  3'sd0,  3'sd2,   3'sd2,  3'sd2,  3'sd0
	};

endpackage
`default_nettype wire

>>> rtl/core/fos_pipe_div.sv
// fos_pipe_div: pipelined restoring divider, one quotient bit per stage
// depends on fos_pkg for default shapes
`default_nettype none
module fos_pipe_div #(
	parameter int DEN_W  = fos_pkg::MEMB_W,
	parameter int Q_W    = fos_pkg::SLOPE_Q_W,
	parameter int SIDE_W = 2
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [DEN_W-1:0]  rem_in,   // upper dividend part, below den_in
	input  wire logic [Q_W-1:0]    low_in,   // dividend bits shifted in msb first
	input  wire logic [DEN_W-1:0]  den_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic      [Q_W-1:0]    quo_out,
	output logic      [SIDE_W-1:0] side_out
);
	import fos_pkg::*;

	// low bits and quotient bits share one shift register
	logic [Q_W-1:0]    qs_s   [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic [DEN_W-1:0]  rem_s  [Q_W-1];
	logic [DEN_W-1:0]  den_s  [Q_W-1];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W-1:0]  r_prev;
		logic [DEN_W-1:0]  d_prev;
		logic [Q_W-1:0]    q_prev;
		logic [SIDE_W-1:0] sd_prev;
		logic [DEN_W:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign r_prev  = rem_in;
			assign d_prev  = den_in;
			assign q_prev  = low_in;
			assign sd_prev = side_in;
		end else begin : g_next
			assign r_prev  = rem_s[k-1];
			assign d_prev  = den_s[k-1];
			assign q_prev  = qs_s[k-1];
			assign sd_prev = side_s[k-1];
		end

		assign trial = {r_prev, q_prev[Q_W-1]};
		assign ge    = trial >= {1'b0, d_prev};

		always_ff @(posedge clk) begin
			if (en) begin
				qs_s[k]   <= {q_prev[Q_W-2:0], ge};
				side_s[k] <= sd_prev;
			end
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? DEN_W'(trial - {1'b0, d_prev}) : trial[DEN_W-1:0];
					den_s[k] <= d_prev;
				end
			end
		end
	end

	assign quo_out  = qs_s[Q_W-1];
	assign side_out = side_s[Q_W-1];

endmodule
`default_nettype wire

>>> rtl/core/fos_lane.sv
// fos_lane: fuzzifies one distance into near, medium and far memberships
// depends on fos_pkg and fos_pipe_div
`default_nettype none
module fos_lane (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire fos_pkg::fos_cfg_t          cfg,
	input  wire logic [fos_pkg::DIST_W-1:0] distance,
	output fos_pkg::memb_set_t              memb
);
	import fos_pkg::*;

	logic [1:0]        mode_c [3];
	logic [MEMB_W-1:0] num_c  [3];
	logic [MEMB_W-1:0] den_c  [3];
	logic [1:0]        mode_s1 [3];
	logic [MEMB_W-1:0] num_s1  [3];
	logic [MEMB_W-1:0] den_s1  [3];

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			mode_c[m] = MODE_ZERO;
			num_c[m]  = '0;
			den_c[m]  = '0;
		end
		// near: falling trapezoid
		if (distance <= cfg.near_full_until) begin
			mode_c[0] = MODE_ONE;
		end else if (distance < cfg.near_zero_from) begin
			mode_c[0] = MODE_SLOPE;
			num_c[0]  = cfg.near_zero_from - distance;
			den_c[0]  = cfg.near_zero_from - cfg.near_full_until;
		end
		// medium: triangle, the peak itself is exactly one
		if (distance > cfg.medium_rise_start && distance < cfg.medium_fall_end) begin
			if (distance < cfg.medium_peak_at) begin
				mode_c[1] = MODE_SLOPE;
				num_c[1]  = distance - cfg.medium_rise_start;
				den_c[1]  = cfg.medium_peak_at - cfg.medium_rise_start;
			end else if (distance == cfg.medium_peak_at) begin
				mode_c[1] = MODE_ONE;
			end else begin
				mode_c[1] = MODE_SLOPE;
				num_c[1]  = cfg.medium_fall_end - distance;
				den_c[1]  = cfg.medium_fall_end - cfg.medium_peak_at;
			end
		end
		// far: rising trapezoid
		if (distance > cfg.far_rise_start) begin
			if (distance >= cfg.far_full_from) begin
				mode_c[2] = MODE_ONE;
			end else begin
				mode_c[2] = MODE_SLOPE;
				num_c[2]  = distance - cfg.far_rise_start;
				den_c[2]  = cfg.far_full_from - cfg.far_rise_start;
			end
		end
	end

	for (genvar m = 0; m < 3; m++) begin : g_set
		logic [SLOPE_Q_W-1:0] quo;
		logic [1:0]           mode_out;

		always_ff @(posedge clk) begin
			if (en) begin
				mode_s1[m] <= mode_c[m];
				num_s1[m]  <= num_c[m];
				den_s1[m]  <= den_c[m];
			end
		end

		fos_pipe_div #(
			.DEN_W  (MEMB_W),
			.Q_W    (SLOPE_Q_W),
			.SIDE_W (2)
		) u_div (
			.clk      (clk),
			.en       (en),
			.rem_in   (num_s1[m]),
			.low_in   ('0),
			.den_in   (den_s1[m]),
			.side_in  (mode_s1[m]),
			.quo_out  (quo),
			.side_out (mode_out)
		);

		assign memb[m] = (mode_out == MODE_ONE)   ? MEMB_ONE :
		                 (mode_out == MODE_SLOPE) ? MEMB_W'(quo) : '0;
	end

endmodule
`default_nettype wire

>>> rtl/core/fos_merge.sv
// fos_merge: min inference over 27 rules, weighted sums and rounded average
// depends on fos_pkg and fos_pipe_div
`default_nettype none
module fos_merge (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire fos_pkg::memb_set_t ml,
	input  wire fos_pkg::memb_set_t mm,
	input  wire fos_pkg::memb_set_t mr,
	output fos_pkg::fos_out_t       result
);
	import fos_pkg::*;

	logic [MEMB_W-1:0]        strength_c  [27];
	logic [MEMB_W-1:0]        strength_s1 [27];
	logic signed [20:0]       lsum_c  [3];
	logic [18:0]              dsum_c  [3];
	logic signed [20:0]       lsum_s2 [3];
	logic [18:0]              dsum_s2 [3];
	logic signed [22:0]       lsum_s3;
	logic [19:0]              dsum_s3;
	logic [21:0]              mag;
	logic [AVG_NUM_W-1:0]     num_s4;
	logic [AVG_DEN_W-1:0]     den_s4;
	logic                     neg_s4;
	logic                     none_s4;
	logic [AVG_Q_W-1:0]       quo;
	logic [1:0]               side_out;

	// rule strengths, a membership at threshold or below kills the rule
	always_comb begin
		logic [MEMB_W-1:0] s;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					s = ml[i];
					if (mm[j] < s) s = mm[j];
					if (mr[k] < s) s = mr[k];
					if (ml[i] <= MEMB_THRESH || mm[j] <= MEMB_THRESH ||
					    mr[k] <= MEMB_THRESH)
						s = '0;
					strength_c[i*9 + j*3 + k] = s;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) strength_s1 <= strength_c;
	end

	// partial sums per left set
	always_comb begin
		logic signed [17:0] sx;
		logic signed [17:0] lx;
		for (int i = 0; i < 3; i++) begin
			lsum_c[i] = '0;
			dsum_c[i] = '0;
			for (int n = 0; n < 9; n++) begin
				sx = {2'b00, strength_s1[i*9 + n]};
				lx = {{15{STEER_LEVEL[i*9 + n][2]}}, STEER_LEVEL[i*9 + n]};
				lsum_c[i] = lsum_c[i] + 21'(sx * lx);
				dsum_c[i] = dsum_c[i] + 19'(strength_s1[i*9 + n]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lsum_s2 <= lsum_c;
			dsum_s2 <= dsum_c;
			lsum_s3 <= 23'(lsum_s2[0]) + 23'(lsum_s2[1]) + 23'(lsum_s2[2]);
			dsum_s3 <= 20'(dsum_s2[0]) + 20'(dsum_s2[1]) + 20'(dsum_s2[2]);
		end
	end

	// dividend 2*6144*|sum| + den, divisor 2*den: round half away from zero
	assign mag = lsum_s3[22] ? 22'(-lsum_s3) : lsum_s3[21:0];

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= (AVG_NUM_W'(mag) << 13) + (AVG_NUM_W'(mag) << 12) +
			           AVG_NUM_W'(dsum_s3);
			den_s4  <= {dsum_s3, 1'b0};
			neg_s4  <= lsum_s3[22];
			none_s4 <= dsum_s3 <= 20'(MEMB_THRESH);
		end
	end

	fos_pipe_div #(
		.DEN_W  (AVG_DEN_W),
		.Q_W    (AVG_Q_W),
		.SIDE_W (2)
	) u_div (
		.clk      (clk),
		.en       (en),
		.rem_in   (num_s4[AVG_NUM_W-1:AVG_Q_W]),
		.low_in   (num_s4[AVG_Q_W-1:0]),
		.den_in   (den_s4),
		.side_in  ({neg_s4, none_s4}),
		.quo_out  (quo),
		.side_out (side_out)
	);

	always_comb begin
		result.no_rule_fired = side_out[0];
		if (side_out[0])
			result.steer_offset = '0;
		else if (side_out[1])
			result.steer_offset = -$signed({1'b0, quo});
		else
			result.steer_offset = $signed({1'b0, quo});
	end

endmodule
`default_nettype wire

>>> rtl/core/fuzzy_obstacle_steering_unit.sv
// fuzzy_obstacle_steering_unit: top level, register port, lanes, merge and output register
// depends on fos_pkg, fos_lane, fos_merge
//
// Takes one item (left, middle and right distance, unsigned Q12.4 cm) per clock while
// in_ready is high and returns one steering item per input item, in order. Three lanes
// fuzzify the three distances side by side into near, medium and far memberships; each
// slope is a 15-stage pipelined divider. The merge stage takes the minimum over the 27
// rules, forms the weighted sums in a registered tree and divides them in a 14-stage
// pipelined divider, rounding to nearest with ties away from zero. Throughput is one
// item per cycle while the output is not stalled. The whole pipeline advances whenever
// the output register is empty or being taken, so a stalled output holds every stage.
// Breakpoint registers sit on an APB port at byte addresses 0x00..0x18 and must be
// written only while no item is in flight.
`default_nettype none
module fuzzy_obstacle_steering_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// input items
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire fos_pkg::fos_in_t            in_data,
	// result items
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output fos_pkg::fos_out_t                out_data,
	// register port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [fos_pkg::PADDR_W-1:0] paddr,
	input  wire logic [fos_pkg::PDATA_W-1:0] pwdata,
	output logic      [fos_pkg::PDATA_W-1:0] prdata,
	output logic                             pready
);
	import fos_pkg::*;

	fos_cfg_t              cfg_q;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  wr_en;
	logic                  adv;
	logic [PIPE_LAT-1:0]   vld_q;
	logic                  out_valid_q;
	fos_out_t              out_data_q;
	memb_set_t             memb_l;
	memb_set_t             memb_m;
	memb_set_t             memb_r;
	fos_out_t              result;

	// register port, zero wait state
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_full_until   <= 16'd480;
			cfg_q.near_zero_from    <= 16'd1120;
			cfg_q.medium_rise_start <= 16'd800;
			cfg_q.medium_peak_at    <= 16'd1280;
			cfg_q.medium_fall_end   <= 16'd1760;
			cfg_q.far_rise_start    <= 16'd1440;
			cfg_q.far_full_from     <= 16'd2400;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_NEAR_FULL_UNTIL:   cfg_q.near_full_until   <= pwdata[DIST_W-1:0];
				REG_NEAR_ZERO_FROM:    cfg_q.near_zero_from    <= pwdata[DIST_W-1:0];
				REG_MEDIUM_RISE_START: cfg_q.medium_rise_start <= pwdata[DIST_W-1:0];
				REG_MEDIUM_PEAK_AT:    cfg_q.medium_peak_at    <= pwdata[DIST_W-1:0];
				REG_MEDIUM_FALL_END:   cfg_q.medium_fall_end   <= pwdata[DIST_W-1:0];
				REG_FAR_RISE_START:    cfg_q.far_rise_start    <= pwdata[DIST_W-1:0];
				REG_FAR_FULL_FROM:     cfg_q.far_full_from     <= pwdata[DIST_W-1:0];
				default: ; // unmapped address, write dropped
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_NEAR_FULL_UNTIL:   prdata = PDATA_W'(cfg_q.near_full_until);
			REG_NEAR_ZERO_FROM:    prdata = PDATA_W'(cfg_q.near_zero_from);
			REG_MEDIUM_RISE_START: prdata = PDATA_W'(cfg_q.medium_rise_start);
			REG_MEDIUM_PEAK_AT:    prdata = PDATA_W'(cfg_q.medium_peak_at);
			REG_MEDIUM_FALL_END:   prdata = PDATA_W'(cfg_q.medium_fall_end);
			REG_FAR_RISE_START:    prdata = PDATA_W'(cfg_q.far_rise_start);
			REG_FAR_FULL_FROM:     prdata = PDATA_W'(cfg_q.far_full_from);
			default:               prdata = '0;
		endcase
	end

	// pipeline moves whenever the output register can take what comes out
	assign adv      = ~out_valid_q | out_ready;
	assign in_ready = adv;

	// one valid bit per pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[PIPE_LAT-2:0], in_valid};
			out_valid_q <= vld_q[PIPE_LAT-1];
		end
	end

	// one lane per sensor
	fos_lane u_lane_l (
		.clk      (clk),
		.en       (adv),
		.cfg      (cfg_q),
		.distance (in_data.left_distance),
		.memb     (memb_l)
	);

	fos_lane u_lane_m (
		.clk      (clk),
		.en       (adv),
		.cfg      (cfg_q),
		.distance (in_data.middle_distance),
		.memb     (memb_m)
	);

	fos_lane u_lane_r (
		.clk      (clk),
		.en       (adv),
		.cfg      (cfg_q),
		.distance (in_data.right_distance),
		.memb     (memb_r)
	);

	// rule evaluation and defuzzification
	fos_merge u_merge (
		.clk    (clk),
		.en     (adv),
		.ml     (memb_l),
		.mm     (memb_m),
		.mr     (memb_r),
		.result (result)
	);

	// output register
	always_ff @(posedge clk) begin
		if (adv) out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

>>> rtl/core/fos_checker.sv
// fos_checker: port-level assertions for the fuzzy obstacle steering unit, bound to the top
// depends on fos_pkg and fuzzy_obstacle_steering_unit
`default_nettype none
module fos_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire fos_pkg::fos_in_t            in_data,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire fos_pkg::fos_out_t           out_data,
	input wire logic                        psel,
	input wire logic                        penable,
	input wire logic                        pwrite,
	input wire logic [fos_pkg::PADDR_W-1:0] paddr,
	input wire logic [fos_pkg::PDATA_W-1:0] pwdata,
	input wire logic [fos_pkg::PDATA_W-1:0] prdata,
	input wire logic                        pready
);
	import fos_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// empty output means the pipeline must take input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// no fired rule forces a zero offset
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.no_rule_fired |-> out_data.steer_offset == 15'sd0)
		else $error("offset not zero when no rule fired");

	// the average stays within the big left and big right levels
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.steer_offset >= -15'sd12288 &&
		              out_data.steer_offset <= 15'sd12288)
		else $error("offset out of range");

endmodule

bind fuzzy_obstacle_steering_unit fos_checker u_fos_checker (.*);
`default_nettype wire

>>> tb/sv/fos_steering_board.sv
// fos_steering_board: expected steering results and the fuzzy steering predictor
// depends on fos_pkg for the item and breakpoint types
`timescale 1ns / 100ps
class fos_steering_board;
	fos_pkg::fos_cfg_t bp;
	fos_pkg::fos_out_t pending[$];
	int errors;

	function new();
		errors = 0;
		bp.near_full_until = 16'd480;
		bp.near_zero_from = 16'd1120;
		bp.medium_rise_start = 16'd800;
		bp.medium_peak_at = 16'd1280;
		bp.medium_fall_end = 16'd1760;
		bp.far_rise_start = 16'd1440;
		bp.far_full_from = 16'd2400;
	endfunction

	function int unsigned ramp(int unsigned span, int unsigned width);
		return (span << 15) / width;
	endfunction

	function void grade(logic [15:0] d, output int unsigned m [3]);
		if (d <= bp.near_full_until) m[0] = 32768;
		else if (d >= bp.near_zero_from) m[0] = 0;
		else m[0] = ramp(bp.near_zero_from - d, bp.near_zero_from - bp.near_full_until);
		if (d <= bp.medium_rise_start || d >= bp.medium_fall_end) m[1] = 0;
		else if (d < bp.medium_peak_at)
			m[1] = ramp(d - bp.medium_rise_start, bp.medium_peak_at - bp.medium_rise_start);
		else m[1] = ramp(bp.medium_fall_end - d, bp.medium_fall_end - bp.medium_peak_at);
		if (d <= bp.far_rise_start) m[2] = 0;
		else if (d >= bp.far_full_from) m[2] = 32768;
		else m[2] = ramp(d - bp.far_rise_start, bp.far_full_from - bp.far_rise_start);
	endfunction

	// min inference over 27 rules, weighted average of steering levels
	function void note_triple(fos_pkg::fos_in_t t);
		int unsigned ml [3], mm [3], mr [3];
		longint wsum, q;
		longint unsigned tot, mag, s;
		fos_pkg::fos_out_t r;
		wsum = 0;
		tot = 0;
		grade(t.left_distance, ml);
		grade(t.middle_distance, mm);
		grade(t.right_distance, mr);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++) begin
					if (ml[i] > 3 && mm[j] > 3 && mr[k] > 3) begin
						s = ml[i];
						if (mm[j] < s) s = mm[j];
						if (mr[k] < s) s = mr[k];
						wsum += longint'(s) * fos_pkg::STEER_LEVEL[i*9+j*3+k] * 6144;
						tot += s;
					end
				end
		if (tot <= 3) begin
			r.steer_offset = '0;
			r.no_rule_fired = 1'b1;
		end else begin
			mag = (wsum < 0) ? -wsum : wsum;
			q = (mag * 2 + tot) / (tot * 2);
			r.steer_offset = (wsum < 0) ? 15'(-q) : 15'(q);
			r.no_rule_fired = 1'b0;
		end
		pending.push_back(r);
	endfunction

	function void check_result(fos_pkg::fos_out_t got);
		fos_pkg::fos_out_t want;
		if (pending.size() == 0) begin
			$error("unexpected result item %h", got);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.steer_offset !== want.steer_offset) begin
			$error("steer_offset expected %0d actual %0d", want.steer_offset, got.steer_offset);
			errors++;
		end
		if (got.no_rule_fired !== want.no_rule_fired) begin
			$error("no_rule_fired expected %0d actual %0d", want.no_rule_fired,
				got.no_rule_fired);
			errors++;
		end
	endfunction
endclass

>>> tb/sv/fuzzy_obstacle_steering_unit_tb.sv
// fuzzy_obstacle_steering_unit_tb: random and directed test of the fuzzy steering unit
// depends on fos_pkg, the unit's RTL and fos_steering_board
`timescale 1ns / 100ps
module fuzzy_obstacle_steering_unit_tb;
	import fos_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	fos_in_t in_data;
	fos_out_t out_data;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;

	fos_steering_board board;
	// idle percentage per side; zero during the quiet stretch
	int unsigned send_idle, take_idle;
	// receiver hold-off length in cycles, counted by the receiver process
	int unsigned hold_cycles;

	fuzzy_obstacle_steering_unit DUT (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("fuzzy_obstacle_steering_unit_tb: FAIL");
		$finish;
	end

	// receiver: random stalls, plus an optional long hold-off
	initial begin
		out_ready = 0;
		hold_cycles = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) board.check_result(out_data);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= take_idle);
			end
		end
	end

	// apb write: setup then access, pready always high; bus released by the caller
	task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [15:0] v);
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= {16'h0, v};
		pwrite <= 1'b1;
		psel <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_NEAR_FULL_UNTIL: board.bp.near_full_until = v;
			REG_NEAR_ZERO_FROM: board.bp.near_zero_from = v;
			REG_MEDIUM_RISE_START: board.bp.medium_rise_start = v;
			REG_MEDIUM_PEAK_AT: board.bp.medium_peak_at = v;
			REG_MEDIUM_FALL_END: board.bp.medium_fall_end = v;
			REG_FAR_RISE_START: board.bp.far_rise_start = v;
			default: board.bp.far_full_from = v;
		endcase
	endtask

	task automatic load_breakpoints(logic [15:0] a, b, c, d, e, f, g);
		reg_write(REG_NEAR_FULL_UNTIL, a);
		reg_write(REG_NEAR_ZERO_FROM, b);
		reg_write(REG_MEDIUM_RISE_START, c);
		reg_write(REG_MEDIUM_PEAK_AT, d);
		reg_write(REG_MEDIUM_FALL_END, e);
		reg_write(REG_FAR_RISE_START, f);
		reg_write(REG_FAR_FULL_FROM, g);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// offer one triple after a random gap, hold until accepted
	task automatic send_triple(logic [15:0] l, m, r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{l, m, r};
		do @(posedge clk); while (!in_ready);
		board.note_triple('{l, m, r});
	endtask

	// distance near the breakpoints most of the time, else anywhere or up to 4000
	function automatic logic [15:0] pick_distance();
		logic [15:0] pts [7];
		pts = '{board.bp.near_full_until, board.bp.near_zero_from, board.bp.medium_rise_start,
			board.bp.medium_peak_at, board.bp.medium_fall_end, board.bp.far_rise_start,
			board.bp.far_full_from};
		case ($urandom_range(9))
			0, 1: return 16'($urandom);
			2: return 16'($urandom_range(4000));
			default: return pts[$urandom_range(6)] + 16'($urandom_range(40)) - 16'd20;
		endcase
	endfunction

	// wait out the pipeline before touching registers
	task automatic drain();
		int unsigned guard;
		guard = 0;
		in_valid <= 1'b0;
		while (board.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (PIPE_LAT + 10) @(posedge clk);
	endtask

	task automatic random_burst(int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_triple(pick_distance(), pick_distance(), pick_distance());
	endtask

	initial begin
		board = new();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		send_idle = 24;
		take_idle = 24;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, all-near, all-far, thresholds around breakpoints
		send_triple(16'h0000, 16'h0000, 16'h0000);
		send_triple(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_triple(16'h0000, 16'hFFFF, 16'h0000);
		send_triple(16'hFFFF, 16'h0000, 16'hFFFF);
		send_triple(16'd480, 16'd1280, 16'd2400);
		send_triple(16'd1120, 16'd800, 16'd1760);
		send_triple(16'd1119, 16'd801, 16'd1759);
		send_triple(16'd1440, 16'd1441, 16'd2399);
		send_triple(16'd1280, 16'd1280, 16'd1280);
		send_triple(16'd2000, 16'd500, 16'd1000);
		send_triple(16'hAAAA, 16'h5555, 16'h1234);
		send_triple(16'd1100, 16'd1600, 16'd481);
		drain();

		// defaults, with a quiet stretch and a long receiver hold-off
		random_burst(400);
		send_idle = 0;
		take_idle = 0;
		random_burst(150);
		hold_cycles = 300;
		random_burst(150);
		send_idle = 24;
		take_idle = 24;
		drain();

		// tight breakpoints, slopes one step wide
		load_breakpoints(16'd100, 16'd101, 16'd100, 16'd101, 16'd102, 16'd101, 16'd102);
		random_burst(250);
		drain();

		// extremes: breakpoints spanning the full distance range
		load_breakpoints(16'd0, 16'hFFFF, 16'd0, 16'h8000, 16'hFFFF, 16'd0, 16'hFFFF);
		send_triple(16'h0001, 16'h7FFF, 16'hFFFE);
		random_burst(250);
		drain();

		// badly ordered breakpoints
		load_breakpoints(16'hFFFF, 16'd0, 16'd3000, 16'd1000, 16'd500, 16'd4000, 16'd2000);
		random_burst(200);
		drain();

		// random ordered breakpoints, then back to reset values
		begin
			logic [15:0] b;
			b = 16'($urandom_range(2000));
			load_breakpoints(b, b + 16'd700, b + 16'd300, b + 16'd900, b + 16'd1500,
				b + 16'd1200, b + 16'd2200);
		end
		random_burst(250);
		drain();
		load_breakpoints(16'd480, 16'd1120, 16'd800, 16'd1280, 16'd1760, 16'd1440, 16'd2400);
		random_burst(250);
		drain();

		if (board.pending.size() != 0) begin
			$error("%0d expected results never arrived", board.pending.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("fuzzy_obstacle_steering_unit_tb: PASS");
		else
			$display("fuzzy_obstacle_steering_unit_tb: FAIL");
		$finish;
	end
endmodule
